/* design/ckt_pkg.sv */
// ============================================================================
// ckt_pkg
// Shared sizes, operation and status codes, and the command and status
// bundles that pass between the compact key table controller and datapath.
// ============================================================================
package ckt_pkg;

   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int KEY_FIELD_W = 64;
   localparam int POS_W       = 4;
   localparam int MAX_OUT     = 16;

   typedef logic [1:0] op_type;
   typedef logic [2:0] status_type;

   localparam op_type OP_CREATE = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;
   localparam op_type OP_LIST   = 2'd3;

   localparam status_type ST_CREATED  = 3'd0;
   localparam status_type ST_FULL     = 3'd1;
   localparam status_type ST_EXISTS   = 3'd2;
   localparam status_type ST_DELETED  = 3'd3;
   localparam status_type ST_NOTFOUND = 3'd4;
   localparam status_type ST_FOUND    = 3'd5;
   localparam status_type ST_LISTED   = 3'd6;
   localparam status_type ST_EMPTY    = 3'd7;

   typedef struct packed {
      logic       accept;
      logic       walk;
      logic       shift_wr;
      logic       shift_start;
      logic       create_wr;
      logic       count_dec;
      logic       stage;
      status_type stage_status;
      logic       emit;
      logic       list_emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   hit;
      logic   walk_end;
      logic   list_last;
      logic   out_free;
   } stat_type;

endpackage

/* design/compact_key_table.sv */
// ============================================================================
// compact_key_table
// Densely packed table of unique keys in insertion order, with create,
// delete, search and list operations.
// ============================================================================
// One request word is taken at a time; req_stall stays high until its last
// result word has been placed in the output register. Every cost comes from
// the single read port of the entry RAM, walked one slot a cycle with a
// registered read. With N entries held: create, search and delete walk up
// to all N slots; a delete that hits at slot s then shifts slots s + 1 to
// N - 1 down by one; a full create or an empty list is answered without a
// walk; a list reads and emits each entry in turn, in slot order. A result
// word held by rsp_stall does not block acceptance of the next request.
// ============================================================================
module compact_key_table import ckt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [KEY_FIELD_W-1:0] req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [POS_W-1:0]       rsp_position,
   output logic [KEY_FIELD_W-1:0] rsp_entry_key,
   output logic                   rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   ckt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   ckt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_key       (req_key),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_entry_key (rsp_entry_key),
      .rsp_last      (rsp_last)
   );

endmodule

/* design/ckt_ram.sv */
// ============================================================================
// ckt_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module ckt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ckt_dp.sv */
// ============================================================================
// ckt_dp
// Datapath: entry RAM, entry count, walk pointer with compare stage, result
// staging and the output word register.
// ============================================================================
module ckt_dp import ckt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  op_type                 req_operation,
   input  logic [KEY_FIELD_W-1:0] req_key,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output status_type             rsp_status,
   output logic [POS_W-1:0]       rsp_position,
   output logic [KEY_FIELD_W-1:0] rsp_entry_key,
   output logic                   rsp_last
);

   localparam int CNT1_W = CNT_W + 1;

   op_type                 op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   status_type             res_status_ff, res_status_in;
   logic [POS_W-1:0]       res_pos_ff, res_pos_in;
   logic [KEY_FIELD_W-1:0] res_key_ff, res_key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [KEY_FIELD_W-1:0] rsp_key_ff, rsp_key_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [KEY_WIDTH-1:0]   ram_wdata;
   logic [KEY_WIDTH-1:0]   ram_rdata;
   logic                   list_last;

   assign ram_we    = cmd.create_wr || (cmd.shift_wr && chk_vld_ff);
   assign ram_waddr = cmd.create_wr ? count_ff[IDX_W-1:0] : chk_idx_ff - IDX_W'(1);
   assign ram_wdata = cmd.create_wr ? key_ff : ram_rdata;

   ckt_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign list_last = (CNT1_W'(idx_ff) + CNT1_W'(1) >= CNT1_W'(count_ff)) ||
                      (32'(idx_ff) >= MAX_OUT - 1);

   always_comb begin
      stat.op        = op_ff;
      stat.full      = count_ff >= CNT_W'(DEPTH);
      stat.empty     = count_ff == '0;
      stat.hit       = chk_vld_ff && (ram_rdata == key_ff);
      stat.walk_end  = !chk_vld_ff && (idx_ff >= count_ff);
      stat.list_last = list_last;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      hit_idx_in = hit_idx_ff;

      if (cmd.accept) begin
         op_in      = req_operation;
         key_in     = req_key[KEY_WIDTH-1:0];
         idx_in     = '0;
         chk_vld_in = 1'b0;
      end else if (cmd.shift_start) begin
         hit_idx_in = chk_idx_ff;
         idx_in     = CNT_W'(chk_idx_ff) + CNT_W'(1);
         chk_vld_in = 1'b0;
      end else if (cmd.walk) begin
         idx_in     = (idx_ff < count_ff) ? idx_ff + CNT_W'(1) : idx_ff;
         chk_vld_in = idx_ff < count_ff;
         chk_idx_in = idx_ff[IDX_W-1:0];
      end else if (cmd.list_emit) begin
         idx_in     = idx_ff + CNT_W'(1);
      end

      if (cmd.create_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_key_in    = res_key_ff;
      if (cmd.stage) begin
         res_status_in = cmd.stage_status;
         res_pos_in    = '0;
         res_key_in    = '0;
         case (cmd.stage_status)
            ST_CREATED: begin
               res_pos_in = POS_W'(count_ff);
            end
            ST_DELETED: begin
               res_pos_in = POS_W'(hit_idx_ff);
            end
            ST_FOUND: begin
               res_pos_in = POS_W'(chk_idx_ff);
               res_key_in = KEY_FIELD_W'(ram_rdata);
            end
            default: begin
               res_pos_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
         rsp_key_in    = res_key_ff;
         rsp_last_in   = 1'b1;
      end else if (cmd.list_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_LISTED;
         rsp_pos_in    = POS_W'(idx_ff);
         rsp_key_in    = KEY_FIELD_W'(ram_rdata);
         rsp_last_in   = list_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_entry_key = rsp_key_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* design/ckt_ctrl.sv */
// ============================================================================
// ckt_ctrl
// Controller: sequences the scan, shift, list and result phases of one
// request word.
// ============================================================================
module ckt_ctrl import ckt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  op_type   req_operation,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_LREAD = 3'd4;
   localparam logic [2:0] S_LOUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_operation == OP_CREATE && stat.full) begin
                  cmd.stage        = 1'b1;
                  cmd.stage_status = ST_FULL;
                  state_in         = S_EMIT;
               end else if (req_operation == OP_LIST) begin
                  if (stat.empty) begin
                     cmd.stage        = 1'b1;
                     cmd.stage_status = ST_EMPTY;
                     state_in         = S_EMIT;
                  end else begin
                     state_in = S_LREAD;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.op == OP_CREATE) begin
                  cmd.stage        = 1'b1;
                  cmd.stage_status = ST_EXISTS;
                  state_in         = S_EMIT;
               end else if (stat.op == OP_DELETE) begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.stage        = 1'b1;
                  cmd.stage_status = ST_FOUND;
                  state_in         = S_EMIT;
               end
            end else if (stat.walk_end) begin
               cmd.stage = 1'b1;
               state_in  = S_EMIT;
               if (stat.op == OP_CREATE) begin
                  cmd.create_wr    = 1'b1;
                  cmd.stage_status = ST_CREATED;
               end else begin
                  cmd.stage_status = ST_NOTFOUND;
               end
            end else begin
               cmd.walk = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.walk_end) begin
               cmd.count_dec    = 1'b1;
               cmd.stage        = 1'b1;
               cmd.stage_status = ST_DELETED;
               state_in         = S_EMIT;
            end else begin
               cmd.walk     = 1'b1;
               cmd.shift_wr = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LREAD: begin
            state_in = S_LOUT;
         end
         S_LOUT: begin
            if (stat.out_free) begin
               cmd.list_emit = 1'b1;
               state_in      = stat.list_last ? S_IDLE : S_LREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
